FILE: sv/base64_stream_decoder_core_assert.svh
// Assertion macros shared by the base64 stream decoder modules.
// Needs nothing but the clock and reset names passed in by the user.
`ifndef BASE64_STREAM_DECODER_CORE_ASSERT_SVH
`define BASE64_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define B64D_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/b64d_pkg.sv
// Shared types, constants and the character map of the base64 stream decoder.
// Used by b64d_decode, b64d_rsp_queue and base64_stream_decoder_core.
package b64d_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_PUSH    = 3;

   localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL_CNT   = QUEUE_CNT_W'(QUEUE_DEPTH);
   localparam logic [QUEUE_CNT_W-1:0] QUEUE_ROOM_LIMIT = QUEUE_CNT_W'(QUEUE_DEPTH - MAX_PUSH);

   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   // Map codes: 0..63 are digits, then the pad and skip codes.
   localparam logic [6:0] CODE_PAD  = 7'd64;
   localparam logic [6:0] CODE_SKIP = 7'd65;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_data;
      logic        done_res;
      logic        status;
      logic [15:0] total_bytes;
   } result_type;

   // Results produced by one item, lowest index first.
   typedef struct packed {
      logic [1:0]                    count;
      result_type [MAX_PUSH-1:0]     res;
   } push_type;

   function automatic logic [6:0] map_char(input logic [7:0] c);
      logic [6:0] code;
      code = CODE_SKIP;
      if (c inside {[8'h41:8'h5A]}) begin
         code = 7'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         code = 7'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         code = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         code = 7'd62;
      end else if (c == 8'h2F) begin
         code = 7'd63;
      end else if (c == 8'h3D) begin
         code = CODE_PAD;
      end
      return code;
   endfunction

endpackage

FILE: sv/b64d_decode.sv
// Group assembly, decode and per-string status of the base64 stream decoder.
// Depends on b64d_pkg and the assertion macro header.
`include "base64_stream_decoder_core_assert.svh"

module b64d_decode import b64d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] max_bytes,
   input  logic        item_vld,
   input  logic [7:0]  item_char,
   input  logic        item_end,
   output push_type    push
);

   logic [5:0]  grp_val_ff [0:2];
   logic [2:0]  grp_pad_ff;
   logic [1:0]  grp_cnt_ff;
   logic [15:0] bytes_ff;
   logic [15:0] bytes_in;
   logic        stopped_ff;
   logic        ovf_ff;
   logic        ovf_in;

   logic [6:0]  code;
   logic        is_pad_char;
   logic        take_char;
   logic        decode_en;
   logic [3:0]  slot_pad;
   logic [23:0] word;
   logic        bad_order;
   logic [1:0]  nbytes;
   logic [16:0] sum;
   logic        over;
   logic        emit;
   logic [1:0]  n_emit;
   logic        stop_set;
   result_type  done_item;
   logic [7:0]  data_byte [0:2];

   always_comb begin
      code        = map_char(item_char);
      is_pad_char = (code == CODE_PAD);
      take_char   = item_vld && !item_end && !stopped_ff && (code != CODE_SKIP);
      decode_en   = (take_char && (grp_cnt_ff == 2'd3)) ||
                    (item_vld && item_end && !stopped_ff);

      // Slots not yet filled at the end of a string count as padding.
      for (int i = 0; i < 3; i++) begin
         slot_pad[i] = (2'(i) < grp_cnt_ff) ? grp_pad_ff[i] : 1'b1;
      end
      slot_pad[3] = item_end ? 1'b1 : is_pad_char;

      word = {slot_pad[0] ? 6'd0 : grp_val_ff[0],
              slot_pad[1] ? 6'd0 : grp_val_ff[1],
              slot_pad[2] ? 6'd0 : grp_val_ff[2],
              slot_pad[3] ? 6'd0 : code[5:0]};

      // Padding must form a suffix of the group.
      bad_order = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (slot_pad[i] && !slot_pad[i+1]) begin
            bad_order = 1'b1;
         end
      end

      case ($countones(slot_pad))
         0:       nbytes = 2'd3;
         1:       nbytes = 2'd2;
         2:       nbytes = 2'd1;
         default: nbytes = 2'd0;
      endcase

      sum      = {1'b0, bytes_ff} + 17'(nbytes);
      over     = sum > {1'b0, max_bytes};
      emit     = decode_en && !bad_order && !over;
      n_emit   = emit ? nbytes : 2'd0;
      bytes_in = emit ? sum[15:0] : bytes_ff;
      ovf_in   = ovf_ff || (decode_en && !bad_order && over);
      stop_set = decode_en && (bad_order || over || (nbytes != 2'd3));

      data_byte[0] = word[23:16];
      data_byte[1] = word[15:8];
      data_byte[2] = word[7:0];

      done_item = '{out_byte: 8'd0, is_data: 1'b0, done_res: 1'b1,
                    status: ovf_in, total_bytes: bytes_in};

      // Data bytes come first; the completion item follows them on an end marker.
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (2'(i) < n_emit) begin
            push.res[i] = '{out_byte: data_byte[i], is_data: 1'b1, done_res: 1'b0,
                            status: 1'b0, total_bytes: 16'd0};
         end else begin
            push.res[i] = done_item;
         end
      end
      push.count = n_emit + {1'b0, item_vld && item_end};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_cnt_ff <= 2'd0;
         bytes_ff   <= 16'd0;
         stopped_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else if (item_vld && item_end) begin
         grp_cnt_ff <= 2'd0;
         bytes_ff   <= 16'd0;
         stopped_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else if (take_char) begin
         if (grp_cnt_ff == 2'd3) begin
            grp_cnt_ff <= 2'd0;
            bytes_ff   <= bytes_in;
            stopped_ff <= stopped_ff || stop_set;
            ovf_ff     <= ovf_in;
         end else begin
            grp_cnt_ff <= grp_cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_char && (grp_cnt_ff != 2'd3)) begin
         grp_val_ff[grp_cnt_ff] <= code[5:0];
         grp_pad_ff[grp_cnt_ff] <= is_pad_char;
      end
   end

   `B64D_ASSERT_NEXT(a_end_clears_string, clock, reset, item_vld && item_end,
      (grp_cnt_ff == 2'd0) && (bytes_ff == 16'd0) && !stopped_ff && !ovf_ff,
      "string state not cleared after end marker")
   `B64D_ASSERT_IMPL(a_stopped_is_silent, clock, reset,
      item_vld && !item_end && stopped_ff, push.count == 2'd0,
      "results produced after decoding stopped")
   `B64D_ASSERT_IMPL(a_end_gives_done, clock, reset, item_vld && item_end,
      (push.count != 2'd0) && push.res[2'(push.count - 2'd1)].done_res,
      "end marker without a completion item last")

endmodule

FILE: sv/b64d_rsp_queue.sv
// Result queue of the base64 stream decoder: takes up to three results a
// cycle and hands out one per transfer. Depends on b64d_pkg and the macro header.
`include "base64_stream_decoder_core_assert.svh"

module b64d_rsp_queue import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output result_type head,
   output logic       not_empty,
   output logic       room
);

   result_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
      head      = mem_ff[rd_ptr_ff];
      not_empty = (count_ff != '0);
      room      = (count_ff <= QUEUE_ROOM_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[wr_ptr_ff + QUEUE_PTR_W'(i)] <= push.res[i];
         end
      end
   end

   `B64D_ASSERT_IMPL(a_count_bounded, clock, reset, 1'b1, count_ff <= QUEUE_FULL_CNT,
      "result queue count beyond its depth")
   `B64D_ASSERT_IMPL(a_push_has_room, clock, reset, push.count != 2'd0,
      count_ff <= QUEUE_ROOM_LIMIT, "results pushed without room in the queue")

endmodule

FILE: sv/base64_stream_decoder_core.sv
// Top level of the base64 stream decoder: input register, decode and result queue.
// Depends on b64d_pkg, b64d_decode and b64d_rsp_queue.
//
// One character or end marker is taken per cycle while the input is not
// stalled. An item is decoded from the input register once the queue has room;
// its results (up to three bytes, or up to two bytes and the completion item)
// enter an eight-entry result queue and leave one per cycle while the result
// side does not stall. The input stalls only while more than five results wait
// in the queue, which happens when the result side stalls; with a free-flowing
// result side the rate is one item every cycle. The capacity register takes
// effect on the next group decoded and is meant to be written between strings.
`include "base64_stream_decoder_core_assert.svh"

module base64_stream_decoder_core import b64d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_marker,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_data,
   output logic        rsp_done_res,
   output logic        rsp_status,
   output logic [15:0] rsp_total_bytes,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic        in_vld_ff;
   logic        in_vld_in;
   logic [7:0]  in_char_ff;
   logic        in_end_ff;
   logic [15:0] capacity_ff;
   logic        room;
   logic        advance;
   logic        accept;
   logic        pop;
   push_type    push;
   result_type  head;

   always_comb begin
      advance   = in_vld_ff && room;
      req_stall = in_vld_ff && !room;
      accept    = req_valid && !req_stall;
      in_vld_in = accept || (in_vld_ff && !advance);
      pop       = rsp_valid && !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         capacity_ff <= CAPACITY_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_code;
         in_end_ff  <= req_end_marker;
      end
   end

   b64d_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .max_bytes (capacity_ff),
      .item_vld  (advance),
      .item_char (in_char_ff),
      .item_end  (in_end_ff),
      .push      (push)
   );

   b64d_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_valid),
      .room      (room)
   );

   assign rsp_out_byte    = head.out_byte;
   assign rsp_is_data     = head.is_data;
   assign rsp_done_res    = head.done_res;
   assign rsp_status      = head.status;
   assign rsp_total_bytes = head.total_bytes;

endmodule
